// ===== src/lzwe_pkg.sv =====
// Package for the LZW letter encoder: item structs, sequencer states and
// fixed code-space constants. No dependencies.
package lzwe_pkg;

  localparam int NUM_LETTERS = 26;
  localparam int CODE_W      = 10;
  localparam int CNT_W       = 11;
  localparam int LET_W       = 5;
  localparam int KEY_W       = CODE_W + LET_W;
  localparam int CODE_SPACE  = 1 << CODE_W;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [LET_W-1:0]  LAST_LETTER = LET_W'(NUM_LETTERS - 1);
  localparam logic [CNT_W-1:0]  FIRST_FREE  = CNT_W'(NUM_LETTERS + 1);
  localparam logic [CNT_W-1:0]  MAX_CODES_RST = CNT_W'(CODE_SPACE);

  // Register index, taken from the word address bit of the APB port.
  localparam logic REG_MAX_CODES = 1'b0;

  typedef struct packed {
    logic [LET_W-1:0] letter;
    logic             end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_code;
    logic              final_code;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } dict_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKA,
    S_LOOKB,
    S_EMIT_MISS,
    S_EMIT_FINAL
  } st_t;

endpackage

// ===== src/lzwe_dict.sv =====
// Dictionary storage of the LZW letter encoder: a key-to-code memory and a
// code-to-key memory, both with registered reads. Depends on lzwe_pkg.
module lzwe_dict #(
  parameter int TBL_DEPTH = 1024,
  parameter int TBL_AW    = 10
) (
  input  logic                       clk,
  input  logic [lzwe_pkg::KEY_W-1:0] a_raddr,
  output logic [lzwe_pkg::CODE_W-1:0] a_rdata,
  input  logic [TBL_AW-1:0]          b_raddr,
  output logic [lzwe_pkg::KEY_W-1:0] b_rdata,
  input  lzwe_pkg::dict_wr_t         wr
);
  import lzwe_pkg::*;

  localparam int KEY_DEPTH = 1 << KEY_W;

  // Key memory maps (prefix, letter) to a candidate code; its contents are
  // only trusted after the code memory confirms the key.
  logic [CODE_W-1:0] key_mem [KEY_DEPTH];
  logic [KEY_W-1:0]  code_mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.key] <= wr.code;
    end
    a_rdata <= key_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      code_mem[wr.code[TBL_AW-1:0]] <= wr.key;
    end
    b_rdata <= code_mem[b_raddr];
  end

endmodule

// ===== src/lzw_letter_encoder_core.sv =====
// Top level of the LZW letter encoder: handshake channels, APB register,
// sequencer and output register. Depends on lzwe_pkg and lzwe_dict.
//
// Usage: the input channel (in_valid/in_ready/in_data) carries one letter
// index per transfer, A as 0 up to Z as 25, with end_of_text set on the last
// letter of a text. The output channel (out_valid/out_ready/out_data) carries
// emitted codes; final_code marks the code that closes a text. A letter
// produces zero, one or two codes.
// Timing: the block works on one letter at a time. A letter that extends the
// prefix passes through accept, key memory read and code memory read. A
// mismatch adds an emit state for the emitted code and the dictionary write,
// and end_of_text adds a further emit state for the flushed code. The two
// dependent memory reads set the pace of a letter.
// Codes leave through a one-entry output register; while it is full and the
// receiver holds out_ready low, the sequencer waits in its emit state and
// in_ready stays low, so nothing is lost.
// Reset clears the prefix, sets the next free code to 27 and max_codes to
// 1024. The memories need no clearing pass: a key lookup is only trusted when
// its code lies below the next free code and the code memory holds the same
// key. The single register max_codes sits at APB byte address 0.
module lzw_letter_encoder_core #(
  parameter int DICT_SIZE = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lzwe_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lzwe_pkg::out_item_t             out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lzwe_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [lzwe_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [lzwe_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import lzwe_pkg::*;

  // Codes never pass the 10-bit code space, so the code memory is cut there.
  localparam int TBL_DEPTH = (DICT_SIZE < CODE_SPACE) ? DICT_SIZE : CODE_SPACE;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam logic [CNT_W-1:0] TBL_LIM = CNT_W'(TBL_DEPTH);

  st_t               state_r, state_nxt;
  logic [LET_W-1:0]  let_r, let_nxt;
  logic              eot_r, eot_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [CODE_W-1:0] ca_r, ca_nxt;
  logic              cand_ok_r, cand_ok_nxt;
  logic [CODE_W-1:0] prefix_r, prefix_nxt;
  logic              pvalid_r, pvalid_nxt;
  logic [CNT_W-1:0]  next_free_r, next_free_nxt;
  logic [CNT_W-1:0]  max_codes_r, max_codes_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              in_xfer;
  logic              slot_free;
  logic              hit;
  logic [LET_W-1:0]  let_sat;
  logic [CODE_W-1:0] lcode;
  logic [CNT_W-1:0]  limit;
  logic              room;
  logic              cfg_wr;
  logic [KEY_W-1:0]  a_raddr;
  logic [CODE_W-1:0] a_rdata;
  logic [KEY_W-1:0]  b_rdata;
  dict_wr_t          dwr;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Letters above Z are taken as Z.
  assign let_sat = (in_data.letter > LAST_LETTER) ? LAST_LETTER : in_data.letter;
  assign lcode   = CODE_W'(let_r) + CODE_W'(1);

  assign limit = (max_codes_r < TBL_LIM) ? max_codes_r : TBL_LIM;
  assign room  = (next_free_r < limit);

  // The key memory is read on every cycle; the data used is the one captured
  // at the edge that accepts the letter.
  assign a_raddr = {prefix_r, let_sat};
  assign hit     = cand_ok_r && (b_rdata == key_r);

  // APB register port.
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == REG_MAX_CODES);
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_CODES) ?
                      CFG_DW'(max_codes_r) : '0;
  assign max_codes_nxt = cfg_wr ? cfg_pwdata[CNT_W-1:0] : max_codes_r;

  lzwe_dict #(
    .TBL_DEPTH(TBL_DEPTH),
    .TBL_AW   (TBL_AW)
  ) u_dict (
    .clk    (clk),
    .a_raddr(a_raddr),
    .a_rdata(a_rdata),
    .b_raddr(a_rdata[TBL_AW-1:0]),
    .b_rdata(b_rdata),
    .wr     (dwr)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (pvalid_r) begin
            state_nxt = S_LOOKA;
          end else if (in_data.end_of_text) begin
            state_nxt = S_EMIT_FINAL;
          end
        end
      end
      S_LOOKA: begin
        state_nxt = S_LOOKB;
      end
      S_LOOKB: begin
        // Only a confirmed hit extends the prefix. A key memory entry that
        // was never written gives no defined hit and lands in the miss arm,
        // which is right since such a key cannot be in the dictionary.
        if (hit) begin
          state_nxt = eot_r ? S_EMIT_FINAL : S_IDLE;
        end else begin
          state_nxt = S_EMIT_MISS;
        end
      end
      S_EMIT_MISS: begin
        if (slot_free) begin
          state_nxt = eot_r ? S_EMIT_FINAL : S_IDLE;
        end
      end
      S_EMIT_FINAL: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    let_nxt       = let_r;
    eot_nxt       = eot_r;
    key_nxt       = key_r;
    ca_nxt        = ca_r;
    cand_ok_nxt   = cand_ok_r;
    prefix_nxt    = prefix_r;
    pvalid_nxt    = pvalid_r;
    next_free_nxt = next_free_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dwr           = '0;
    dwr.key       = key_r;
    dwr.code      = next_free_r[CODE_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          let_nxt = let_sat;
          eot_nxt = in_data.end_of_text;
          key_nxt = {prefix_r, let_sat};
          if (!pvalid_r) begin
            prefix_nxt = CODE_W'(let_sat) + CODE_W'(1);
            pvalid_nxt = 1'b1;
          end
        end
      end
      S_LOOKA: begin
        // A candidate is only real if it is an added code already written.
        ca_nxt      = a_rdata;
        cand_ok_nxt = (CNT_W'(a_rdata) >= FIRST_FREE) &&
                      (CNT_W'(a_rdata) < next_free_r);
      end
      S_LOOKB: begin
        if (hit) begin
          prefix_nxt = ca_r;
        end
      end
      S_EMIT_MISS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.out_code   = prefix_r;
          out_item_nxt.final_code = 1'b0;
          prefix_nxt = lcode;
          if (room) begin
            dwr.en        = 1'b1;
            next_free_nxt = next_free_r + CNT_W'(1);
          end
        end
      end
      S_EMIT_FINAL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt.out_code   = prefix_r;
          out_item_nxt.final_code = 1'b1;
          prefix_nxt = '0;
          pvalid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prefix_r    <= '0;
      pvalid_r    <= 1'b0;
      next_free_r <= FIRST_FREE;
      max_codes_r <= MAX_CODES_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prefix_r    <= prefix_nxt;
      pvalid_r    <= pvalid_nxt;
      next_free_r <= next_free_nxt;
      max_codes_r <= max_codes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    let_r      <= let_nxt;
    eot_r      <= eot_nxt;
    key_r      <= key_nxt;
    ca_r       <= ca_nxt;
    cand_ok_r  <= cand_ok_nxt;
    out_item_r <= out_item_nxt;
  end

  // A new code only appears after an emit state.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      ($past(state_r) == S_EMIT_MISS || $past(state_r) == S_EMIT_FINAL))
    else $error("output code loaded outside an emit state");

  // The next free code stays inside the table.
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_free_r >= FIRST_FREE) && (next_free_r <= TBL_LIM))
    else $error("next free code out of range");

  // The next free code never moves backward.
  a_free_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (next_free_r >= $past(next_free_r)))
    else $error("next free code decreased");

  // A dictionary write only happens while there is room.
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    dwr.en |-> room)
    else $error("dictionary written while full");

  // The flushed code clears the prefix.
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_FINAL && slot_free) |=> !pvalid_r)
    else $error("prefix still held after final code");

endmodule
